[hw/rtl/ubp_pkg.sv]
// shared types and codes for the uri byte parser
`timescale 1ns / 1ps
`default_nettype none
package ubp_pkg;

  // input beat: one uri character or the end mark
  typedef struct packed {
    logic [7:0] byte_in;
    logic       end_marker;
  } ubp_in_t;

  // result beat: tagged character or the final report
  typedef struct packed {
    logic [7:0]  byte_out;
    logic [3:0]  part;
    logic [1:0]  resolve;
    logic        error;
    logic        done_res;
    logic [15:0] port_value;
    logic        is_ipv6;
  } ubp_out_t;

  // part tags
  localparam logic [3:0] PART_DELIM     = 4'd0;
  localparam logic [3:0] PART_SCHEME    = 4'd1;
  localparam logic [3:0] PART_USER_HOST = 4'd2;
  localparam logic [3:0] PART_PASS_PORT = 4'd3;
  localparam logic [3:0] PART_PASS      = 4'd4;
  localparam logic [3:0] PART_HOST      = 4'd5;
  localparam logic [3:0] PART_PORT      = 4'd6;
  localparam logic [3:0] PART_PATH      = 4'd7;
  localparam logic [3:0] PART_QUERY     = 4'd8;
  localparam logic [3:0] PART_FRAG      = 4'd9;

  // resolve codes for pending bytes
  localparam logic [1:0] RES_NONE      = 2'd0;
  localparam logic [1:0] RES_USER_PASS = 2'd1;
  localparam logic [1:0] RES_HOST_PORT = 2'd2;
  localparam logic [1:0] RES_PASS      = 2'd3;

  // scheme default ports and the port clamp value
  localparam logic [15:0] PORT_HTTP  = 16'd80;
  localparam logic [15:0] PORT_HTTPS = 16'd443;
  localparam logic [15:0] PORT_FTP   = 16'd21;
  localparam logic [15:0] PORT_MAX   = 16'hFFFF;

endpackage
`default_nettype wire

[hw/rtl/ubp_parse.sv]
// per-byte parse state machine with the registered result
`timescale 1ns / 1ps
`default_nettype none
module ubp_parse (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             step,
  input  wire ubp_pkg::ubp_in_t item,
  output ubp_pkg::ubp_out_t     res
);
  import ubp_pkg::*;

  typedef enum logic [3:0] {
    ST_START, ST_SCHEME, ST_COLON, ST_SLASH1, ST_SLASH2, ST_USER_HOST,
    ST_PASS_PORT, ST_PASS, ST_HOST, ST_V6, ST_V6OK, ST_V6END, ST_PORT,
    ST_PATH, ST_QUERY, ST_FRAG
  } st_t;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_RBRK  = 8'h5D;
  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  // expected scheme letters by position
  function automatic logic [7:0] http_ch(input logic [2:0] p);
    logic [7:0] c;
    case (p)
      3'd0:    c = 8'h68;
      3'd1:    c = 8'h74;
      3'd2:    c = 8'h74;
      3'd3:    c = 8'h70;
      3'd4:    c = 8'h73;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] ftp_ch(input logic [2:0] p);
    logic [7:0] c;
    case (p)
      3'd0:    c = 8'h66;
      3'd1:    c = 8'h74;
      3'd2:    c = 8'h70;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  st_t         state, state_next;
  logic [15:0] port_acc, port_acc_next;
  logic        port_seen, port_seen_next;
  logic        ipv6_flag, ipv6_flag_next;
  logic        host_empty, host_empty_next;
  logic [2:0]  scheme_len, scheme_len_next;
  logic [2:0]  scheme_match, scheme_match_next;
  logic        error_flag, error_flag_next;
  ubp_out_t    res_next;

  logic [7:0]  c;
  logic        c_alpha, c_digit, c_space, c_hex;
  logic [2:0]  sm_add;
  logic [2:0]  sl_add;
  logic [19:0] port_mul;
  logic [15:0] port_dig;
  logic        ok;
  logic [15:0] port_fin;
  logic [3:0]  part;
  logic [1:0]  rcode;

  // character classes
  always_comb begin
    c       = item.byte_in;
    c_alpha = (c inside {[8'h41:8'h5A], [8'h61:8'h7A]});
    c_digit = (c inside {[8'h30:8'h39]});
    c_space = (c inside {[8'h09:8'h0D], 8'h20});
    c_hex   = c_digit || (c inside {[8'h41:8'h46], [8'h61:8'h66]});
  end

  // scheme name tracking and port digit accumulate
  always_comb begin
    sm_add    = scheme_match;
    if (!(scheme_len < 3'd4 && c == http_ch(scheme_len))) sm_add[0] = 1'b0;
    if (!(scheme_len < 3'd5 && c == http_ch(scheme_len))) sm_add[1] = 1'b0;
    if (!(scheme_len < 3'd3 && c == ftp_ch(scheme_len)))  sm_add[2] = 1'b0;
    sl_add    = (scheme_len < 3'd7) ? scheme_len + 3'd1 : 3'd7;
    // acc * 10 as shifts, plus the digit
    port_mul  = ({4'd0, port_acc} << 3) + ({4'd0, port_acc} << 1)
                + {12'd0, c - CH_ZERO};
    port_dig  = (port_mul > {4'd0, PORT_MAX}) ? PORT_MAX : port_mul[15:0];
  end

  // next state and result
  always_comb begin
    state_next        = state;
    port_acc_next     = port_acc;
    port_seen_next    = port_seen;
    ipv6_flag_next    = ipv6_flag;
    host_empty_next   = host_empty;
    scheme_len_next   = scheme_len;
    scheme_match_next = scheme_match;
    error_flag_next   = error_flag;
    part              = PART_DELIM;
    rcode             = RES_NONE;
    ok                = 1'b0;
    port_fin          = '0;
    res_next          = '0;

    if (item.end_marker) begin
      // final check, then back to the reset state
      ok = !error_flag;
      if (state == ST_USER_HOST) begin
        rcode = RES_HOST_PORT;
      end else if (!(state inside {ST_PORT, ST_HOST, ST_PATH, ST_QUERY, ST_FRAG})) begin
        ok = 1'b0;
      end
      if (!ok) rcode = RES_NONE;
      if (ok) begin
        port_fin = port_acc;
        if (!port_seen) begin
          if (scheme_match[0] && scheme_len == 3'd4) port_fin = PORT_HTTP;
          else if (scheme_match[1] && scheme_len == 3'd5) port_fin = PORT_HTTPS;
          else if (scheme_match[2] && scheme_len == 3'd3) port_fin = PORT_FTP;
        end
      end
      res_next.byte_out   = '0;
      res_next.part       = PART_DELIM;
      res_next.resolve    = rcode;
      res_next.error      = !ok;
      res_next.done_res   = 1'b1;
      res_next.port_value = port_fin;
      res_next.is_ipv6    = ipv6_flag;
      state_next          = ST_START;
      port_acc_next       = '0;
      port_seen_next      = 1'b0;
      ipv6_flag_next      = 1'b0;
      host_empty_next     = 1'b1;
      scheme_len_next     = '0;
      scheme_match_next   = 3'b111;
      error_flag_next     = 1'b0;
    end else begin
      if (!error_flag) begin
        case (state)
          ST_START: begin
            if (c_alpha) begin
              scheme_match_next = sm_add;
              scheme_len_next   = sl_add;
              part              = PART_SCHEME;
              state_next        = ST_SCHEME;
            end else if (!c_space) begin
              error_flag_next = 1'b1;
            end
          end
          ST_SCHEME: begin
            if (c_alpha) begin
              scheme_match_next = sm_add;
              scheme_len_next   = sl_add;
              part              = PART_SCHEME;
            end else if (c == CH_COLON) begin
              state_next = ST_COLON;
            end else begin
              error_flag_next = 1'b1;
            end
          end
          ST_COLON: begin
            if (c == CH_SLASH) state_next = ST_SLASH1;
            else error_flag_next = 1'b1;
          end
          ST_SLASH1: begin
            if (c == CH_SLASH) state_next = ST_SLASH2;
            else error_flag_next = 1'b1;
          end
          ST_SLASH2: begin
            if (c == CH_LBRK) begin
              ipv6_flag_next = 1'b1;
              state_next     = ST_V6;
            end else begin
              part       = PART_USER_HOST;
              state_next = ST_USER_HOST;
            end
          end
          ST_USER_HOST: begin
            if (c == CH_COLON) begin
              state_next = ST_PASS_PORT;
            end else if (c == CH_SLASH) begin
              part       = PART_PATH;
              rcode      = RES_HOST_PORT;
              state_next = ST_PATH;
            end else if (c == CH_AT) begin
              rcode      = RES_USER_PASS;
              state_next = ST_HOST;
            end else begin
              part = PART_USER_HOST;
            end
          end
          ST_PASS_PORT: begin
            if (c == CH_AT) begin
              // digits turned out to be a password: port cleared, still seen
              port_acc_next = '0;
              rcode         = RES_USER_PASS;
              state_next    = ST_HOST;
            end else if (c == CH_SLASH) begin
              part       = PART_PATH;
              rcode      = RES_HOST_PORT;
              state_next = ST_PATH;
            end else if (c_digit) begin
              port_acc_next  = port_dig;
              port_seen_next = 1'b1;
              part           = PART_PASS_PORT;
            end else begin
              port_acc_next  = '0;
              port_seen_next = 1'b0;
              part           = PART_PASS;
              rcode          = RES_PASS;
              state_next     = ST_PASS;
            end
          end
          ST_PASS: begin
            if (c == CH_AT) begin
              rcode      = RES_USER_PASS;
              state_next = ST_HOST;
            end else begin
              part = PART_PASS;
            end
          end
          ST_HOST: begin
            if (c == CH_SLASH) begin
              part       = PART_PATH;
              state_next = ST_PATH;
            end else if (c == CH_COLON) begin
              state_next = ST_PORT;
            end else if (host_empty && c == CH_LBRK) begin
              ipv6_flag_next = 1'b1;
              state_next     = ST_V6;
            end else begin
              part            = PART_HOST;
              host_empty_next = 1'b0;
            end
          end
          ST_V6: begin
            if (c == CH_COLON) begin
              part            = PART_HOST;
              host_empty_next = 1'b0;
              state_next      = ST_V6OK;
            end else if (c_hex) begin
              part            = PART_HOST;
              host_empty_next = 1'b0;
            end else begin
              error_flag_next = 1'b1;
            end
          end
          ST_V6OK: begin
            if (c == CH_RBRK) begin
              state_next = ST_V6END;
            end else if (c_hex || c == CH_COLON) begin
              part            = PART_HOST;
              host_empty_next = 1'b0;
            end else begin
              error_flag_next = 1'b1;
            end
          end
          ST_V6END: begin
            if (c == CH_COLON) begin
              port_seen_next = 1'b1;
              state_next     = ST_PORT;
            end else if (c == CH_SLASH) begin
              part       = PART_PATH;
              state_next = ST_PATH;
            end else begin
              error_flag_next = 1'b1;
            end
          end
          ST_PORT: begin
            if (c == CH_SLASH) begin
              part       = PART_PATH;
              state_next = ST_PATH;
            end else if (c_digit) begin
              port_acc_next  = port_dig;
              port_seen_next = 1'b1;
              part           = PART_PORT;
            end else begin
              error_flag_next = 1'b1;
            end
          end
          ST_PATH: begin
            if (c == CH_QUEST) state_next = ST_QUERY;
            else if (c == CH_HASH) state_next = ST_FRAG;
            else part = PART_PATH;
          end
          ST_QUERY: begin
            if (c == CH_HASH) state_next = ST_FRAG;
            else part = PART_QUERY;
          end
          default: begin
            part = PART_FRAG;
          end
        endcase
      end
      // after an error every byte is a plain delimiter
      if (error_flag_next) begin
        part  = PART_DELIM;
        rcode = RES_NONE;
      end
      res_next.byte_out   = c;
      res_next.part       = part;
      res_next.resolve    = rcode;
      res_next.error      = error_flag_next;
      res_next.done_res   = 1'b0;
      res_next.port_value = '0;
      res_next.is_ipv6    = ipv6_flag_next;
    end
  end

  // parse state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_START;
      port_acc     <= '0;
      port_seen    <= 1'b0;
      ipv6_flag    <= 1'b0;
      host_empty   <= 1'b1;
      scheme_len   <= '0;
      scheme_match <= 3'b111;
      error_flag   <= 1'b0;
    end else if (step) begin
      state        <= state_next;
      port_acc     <= port_acc_next;
      port_seen    <= port_seen_next;
      ipv6_flag    <= ipv6_flag_next;
      host_empty   <= host_empty_next;
      scheme_len   <= scheme_len_next;
      scheme_match <= scheme_match_next;
      error_flag   <= error_flag_next;
      res          <= res_next;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/uri_byte_parser.sv]
// top level: input beat register, parse stage and output handshake
// a beat accepted on in_data passes through the input register, then the result register, to out_data
// throughput: one beat per cycle while out_stall does not hold the result, bounded by the parse state update
// in_stall rises only when the input register is full and the result is held
// reset (rst, synchronous) empties both registers and returns the parser to
// leading-whitespace skipping with the port cleared and no error
`timescale 1ns / 1ps
`default_nettype none
module uri_byte_parser (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire ubp_pkg::ubp_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output ubp_pkg::ubp_out_t      out_data
);
  import ubp_pkg::*;

  logic    in_vld;
  ubp_in_t in_reg;
  logic    advance;
  logic    step;

  // the result register moves when empty or taken
  assign advance  = !out_valid || !out_stall;
  assign step     = in_vld && advance;
  assign in_stall = in_vld && !advance;

  // input beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (!in_stall) begin
      in_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      in_reg <= in_data;
    end
  end

  // result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_vld;
    end
  end

  ubp_parse u_parse (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .item (in_reg),
    .res  (out_data)
  );

  // a beat that is not held moves on to the result register
  a_step_fills_out: assert property (@(posedge clk) disable iff (rst)
    (in_vld && !out_stall) |=> out_valid)
    else $error("parse step did not produce a result beat");

  // an accepted beat lands in the input register
  a_accept_fills_in: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_vld)
    else $error("accepted beat lost before parsing");

  // errored byte results carry no part tag and no resolve
  a_error_is_delim: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.error && !out_data.done_res) |->
      (out_data.part == PART_DELIM && out_data.resolve == RES_NONE))
    else $error("errored byte still tagged");

endmodule
`default_nettype wire

[tb/sv/testbench.sv]
// self-checking testbench for the uri byte parser
`timescale 1ns / 1ps
module testbench;
  import ubp_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int RAND_BEATS  = 600;
  localparam int DIR_N       = 26;
  localparam int HOLD_CYCLES = 400;

  // characters the parser reacts to
  localparam logic [7:0] CH_COLON  = ":";
  localparam logic [7:0] CH_SLASH  = "/";
  localparam logic [7:0] CH_AT     = "@";
  localparam logic [7:0] CH_LBRACK = "[";
  localparam logic [7:0] CH_RBRACK = "]";
  localparam logic [7:0] CH_QMARK  = "?";
  localparam logic [7:0] CH_HASH   = "#";
  localparam logic [7:0] CH_SPACE  = " ";
  localparam logic [7:0] CH_ZERO   = "0";
  localparam logic [39:0] NAME_HTTPS = "https";
  localparam logic [23:0] NAME_FTP   = "ftp";

  localparam string LETTERS  = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ";
  localparam string ALNUM    = {LETTERS, "0123456789"};
  localparam string HOST_SET = {ALNUM, ".-_~"};
  localparam string PATH_SET = {ALNUM, "/-._~%=&+"};
  localparam string DIGITS   = "0123456789";
  localparam string HEX_SET  = "0123456789abcdefABCDEF";
  localparam string V6_SET   = "0123456789abcdefABCDEF:";

  localparam ubp_out_t NO_TAG = '0;

  // parser states of the predictor
  typedef enum logic [3:0] {
    PS_START, PS_SCHEME, PS_COLON, PS_SLASH1, PS_SLASH2, PS_USER_HOST, PS_PASS_PORT,
    PS_PASS, PS_HOST, PS_V6, PS_V6OK, PS_V6END, PS_PORT, PS_PATH, PS_QUERY, PS_FRAG
  } parse_st_t;

  // directed row: the beat, and a typed-in result where one is given
  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
    logic       fixed;
    ubp_out_t   want;
  } dir_row_t;

  logic     clk;
  logic     rst;
  logic     in_valid;
  logic     in_stall;
  ubp_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  ubp_out_t out_data;

  // predictor state
  parse_st_t   pst;
  logic [15:0] port_sum;
  logic        port_given;
  logic        v6_host;
  logic        host_blank;
  logic [2:0]  scheme_cnt;
  logic [2:0]  scheme_ok;
  logic        bad_uri;

  ubp_out_t   tags_due[$];
  ubp_out_t   tag_want;
  logic [7:0] uri_buf[$];
  dir_row_t   dir_tab[DIR_N];

  int fail_cnt;
  int results_seen;
  int beats_sent;
  int valid_uris;
  int bad_uris;
  int port_clamps;
  int v6_hosts;
  int cycle_cnt;
  int quiet_left;
  int hold_cycles;
  int stall_left;
  int free_left;
  logic stall_now;
  logic held;
  logic paused;

  uri_byte_parser dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // character classes
  function automatic logic is_letter(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic void clear_parser();
    pst        = PS_START;
    port_sum   = 16'd0;
    port_given = 1'b0;
    v6_host    = 1'b0;
    host_blank = 1'b1;
    scheme_cnt = 3'd0;
    scheme_ok  = 3'b111;
    bad_uri    = 1'b0;
  endfunction

  // narrow the known-scheme candidates by one letter
  function automatic void scheme_step(input logic [7:0] c);
    if (scheme_cnt >= 3'd4 || c != NAME_HTTPS[8*(4-scheme_cnt) +: 8]) scheme_ok[0] = 1'b0;
    if (scheme_cnt >= 3'd5 || c != NAME_HTTPS[8*(4-scheme_cnt) +: 8]) scheme_ok[1] = 1'b0;
    if (scheme_cnt >= 3'd3 || c != NAME_FTP[8*(2-scheme_cnt) +: 8]) scheme_ok[2] = 1'b0;
    scheme_cnt = (scheme_cnt < 3'd7) ? scheme_cnt + 3'd1 : 3'd7;
  endfunction

  // accumulate one decimal port digit, clamped to 16 bits
  function automatic void port_step(input logic [7:0] c);
    int v;
    v = int'(port_sum) * 10 + int'(c) - int'(CH_ZERO);
    if (v > 65535) begin
      v = 65535;
      port_clamps++;
    end
    port_sum   = 16'(v);
    port_given = 1'b1;
  endfunction

  // expected result of one accepted beat, advancing the predictor state
  function automatic ubp_out_t tag_beat(input ubp_in_t beat);
    ubp_out_t    r;
    logic [7:0]  c;
    logic        good;
    logic [15:0] port;
    r = '0;
    c = beat.byte_in;
    if (beat.end_marker) begin
      good = !bad_uri;
      port = 16'd0;
      if (pst == PS_USER_HOST) r.resolve = RES_HOST_PORT;
      else if (!(pst inside {PS_HOST, PS_PORT, PS_PATH, PS_QUERY, PS_FRAG})) good = 1'b0;
      if (good) begin
        port = port_sum;
        if (!port_given) begin
          if (scheme_ok[0] && scheme_cnt == 3'd4) port = PORT_HTTP;
          else if (scheme_ok[1] && scheme_cnt == 3'd5) port = PORT_HTTPS;
          else if (scheme_ok[2] && scheme_cnt == 3'd3) port = PORT_FTP;
        end
        valid_uris++;
      end else begin
        r.resolve = RES_NONE;
        bad_uris++;
      end
      if (v6_host) v6_hosts++;
      r.error      = !good;
      r.done_res   = 1'b1;
      r.port_value = port;
      r.is_ipv6    = v6_host;
      clear_parser();
    end else begin
      r.byte_out = c;
      if (!bad_uri) begin
        case (pst)
          PS_START: begin
            if (is_letter(c)) begin
              scheme_step(c);
              r.part = PART_SCHEME;
              pst = PS_SCHEME;
            end else if (!(c == CH_SPACE || (c >= 8'd9 && c <= 8'd13))) begin
              bad_uri = 1'b1;
            end
          end
          PS_SCHEME: begin
            if (is_letter(c)) begin
              scheme_step(c);
              r.part = PART_SCHEME;
            end else if (c == CH_COLON) pst = PS_COLON;
            else bad_uri = 1'b1;
          end
          PS_COLON: begin
            if (c == CH_SLASH) pst = PS_SLASH1;
            else bad_uri = 1'b1;
          end
          PS_SLASH1: begin
            if (c == CH_SLASH) pst = PS_SLASH2;
            else bad_uri = 1'b1;
          end
          PS_SLASH2: begin
            if (c == CH_LBRACK) begin
              v6_host = 1'b1;
              pst = PS_V6;
            end else begin
              r.part = PART_USER_HOST;
              pst = PS_USER_HOST;
            end
          end
          PS_USER_HOST: begin
            if (c == CH_COLON) pst = PS_PASS_PORT;
            else if (c == CH_SLASH) begin
              r.part = PART_PATH;
              r.resolve = RES_HOST_PORT;
              pst = PS_PATH;
            end else if (c == CH_AT) begin
              r.resolve = RES_USER_PASS;
              pst = PS_HOST;
            end else r.part = PART_USER_HOST;
          end
          PS_PASS_PORT: begin
            if (c == CH_AT) begin
              port_sum = 16'd0;
              r.resolve = RES_USER_PASS;
              pst = PS_HOST;
            end else if (c == CH_SLASH) begin
              r.part = PART_PATH;
              r.resolve = RES_HOST_PORT;
              pst = PS_PATH;
            end else if (is_digit(c)) begin
              port_step(c);
              r.part = PART_PASS_PORT;
            end else begin
              port_sum = 16'd0;
              port_given = 1'b0;
              r.part = PART_PASS;
              r.resolve = RES_PASS;
              pst = PS_PASS;
            end
          end
          PS_PASS: begin
            if (c == CH_AT) begin
              r.resolve = RES_USER_PASS;
              pst = PS_HOST;
            end else r.part = PART_PASS;
          end
          PS_HOST: begin
            if (c == CH_SLASH) begin
              r.part = PART_PATH;
              pst = PS_PATH;
            end else if (c == CH_COLON) pst = PS_PORT;
            else if (host_blank && c == CH_LBRACK) begin
              v6_host = 1'b1;
              pst = PS_V6;
            end else begin
              r.part = PART_HOST;
              host_blank = 1'b0;
            end
          end
          PS_V6: begin
            if (c == CH_COLON || is_hex(c)) begin
              r.part = PART_HOST;
              host_blank = 1'b0;
              if (c == CH_COLON) pst = PS_V6OK;
            end else bad_uri = 1'b1;
          end
          PS_V6OK: begin
            if (c == CH_RBRACK) pst = PS_V6END;
            else if (is_hex(c) || c == CH_COLON) begin
              r.part = PART_HOST;
              host_blank = 1'b0;
            end else bad_uri = 1'b1;
          end
          PS_V6END: begin
            if (c == CH_COLON) begin
              port_given = 1'b1;
              pst = PS_PORT;
            end else if (c == CH_SLASH) begin
              r.part = PART_PATH;
              pst = PS_PATH;
            end else bad_uri = 1'b1;
          end
          PS_PORT: begin
            if (c == CH_SLASH) begin
              r.part = PART_PATH;
              pst = PS_PATH;
            end else if (is_digit(c)) begin
              port_step(c);
              r.part = PART_PORT;
            end else bad_uri = 1'b1;
          end
          PS_PATH: begin
            if (c == CH_QMARK) pst = PS_QUERY;
            else if (c == CH_HASH) pst = PS_FRAG;
            else r.part = PART_PATH;
          end
          PS_QUERY: begin
            if (c == CH_HASH) pst = PS_FRAG;
            else r.part = PART_QUERY;
          end
          default: r.part = PART_FRAG;
        endcase
      end
      // once broken, bytes carry no tag until the end beat
      if (bad_uri) begin
        r.part = PART_DELIM;
        r.resolve = RES_NONE;
        r.error = 1'b1;
      end
      r.is_ipv6 = v6_host;
    end
    return r;
  endfunction

  function automatic string show(input ubp_out_t t);
    return $sformatf("byte=%h part=%0d res=%0d err=%b done=%b port=%0d v6=%b",
                     t.byte_out, t.part, t.resolve, t.error, t.done_res, t.port_value,
                     t.is_ipv6);
  endfunction

  // sender idle gaps: mostly none, some short, a few long, with calm stretches
  function automatic int pick_gap();
    int r;
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) quiet_left = $urandom_range(30, 120);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // offer one beat after a random gap; predict it once accepted
  task automatic send_beat(input ubp_in_t beat, input logic fixed, input ubp_out_t want);
    int gap;
    ubp_out_t guess;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  <= beat;
    in_valid <= 1'b1;
    do begin
      @(posedge clk);
    end while (in_stall);
    guess = tag_beat(beat);
    tags_due.push_back(fixed ? want : guess);
    beats_sent++;
    @(negedge clk);
  endtask

  // stop offering and wait until every pending result is back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do begin
      @(negedge clk);
    end while (tags_due.size() != 0);
  endtask

  function automatic void put_text(input string s);
    for (int k = 0; k < s.len(); k++) uri_buf.push_back(s[k]);
  endfunction

  function automatic void put_from(input string set, input int n);
    for (int k = 0; k < n; k++) uri_buf.push_back(set[$urandom_range(0, set.len() - 1)]);
  endfunction

  // mostly short ports, sometimes long enough to clamp
  function automatic void put_port();
    put_from(DIGITS, ($urandom_range(0, 5) == 0) ? $urandom_range(5, 7) : $urandom_range(1, 4));
  endfunction

  // path-like text with the odd raw byte anywhere in 0..255
  function automatic void put_wild(input int n);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 5) == 0) uri_buf.push_back(8'($urandom_range(0, 255)));
      else uri_buf.push_back(PATH_SET[$urandom_range(0, PATH_SET.len() - 1)]);
    end
  endfunction

  function automatic void put_v6();
    put_text("[");
    put_from(HEX_SET, $urandom_range(0, 4));
    put_text(":");
    put_from(V6_SET, $urandom_range(0, 10));
    put_text("]");
  endfunction

  // build one uri, mostly well formed, then send it with its end beat
  task automatic send_uri();
    int pos;
    logic [7:0] c;
    ubp_in_t beat;
    uri_buf.delete();
    // leading whitespace now and then
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        c = 8'($urandom_range(8, 13));
        uri_buf.push_back(c == 8'd8 ? CH_SPACE : c);
      end
    end
    // scheme, known and unknown
    case ($urandom_range(0, 9))
      0, 1: put_text("http");
      2, 3: put_text("https");
      4: put_text("ftp");
      5: put_text("HTTP");
      6: put_text("htt");
      7: put_text("httpsx");
      8: put_text("ftps");
      default: put_from(LETTERS, $urandom_range(1, 10));
    endcase
    put_text("://");
    // authority
    case ($urandom_range(0, 9))
      0: put_from(HOST_SET, $urandom_range(1, 8));
      1: begin
        put_from(HOST_SET, $urandom_range(1, 8));
        put_text(":");
        put_port();
      end
      2: begin
        put_from(HOST_SET, $urandom_range(1, 5));
        put_text("@");
        put_from(HOST_SET, $urandom_range(1, 8));
      end
      3: begin
        put_from(HOST_SET, $urandom_range(1, 5));
        put_text(":");
        put_from(LETTERS, 1);
        put_from(ALNUM, $urandom_range(0, 5));
        put_text("@");
        put_from(HOST_SET, $urandom_range(0, 6));
        if ($urandom_range(0, 1) == 0) begin
          put_text(":");
          put_port();
        end
      end
      4: begin
        // digits before the at sign look like a port at first
        put_from(HOST_SET, $urandom_range(1, 5));
        put_text(":");
        put_port();
        put_text("@");
        put_from(HOST_SET, $urandom_range(1, 6));
        if ($urandom_range(0, 1) == 0) begin
          put_text(":");
          if ($urandom_range(0, 2) != 0) put_port();
        end
      end
      5: begin
        put_v6();
        case ($urandom_range(0, 2))
          0: ;
          1: put_text(":");
          default: begin
            put_text(":");
            put_port();
          end
        endcase
      end
      6: begin
        put_from(HOST_SET, $urandom_range(1, 5));
        put_text(":");
        put_port();
      end
      7: ;
      8: put_from(HOST_SET, $urandom_range(1, 8));
      default: begin
        put_from(HOST_SET, $urandom_range(1, 4));
        put_text(":");
        put_from(LETTERS, $urandom_range(1, 4));
        put_text("@");
        put_v6();
        put_text(":");
        put_port();
      end
    endcase
    // path, query and fragment
    if ($urandom_range(0, 3) != 0) begin
      put_text("/");
      put_wild($urandom_range(0, 8));
    end
    if ($urandom_range(0, 2) == 0) begin
      put_text("?");
      put_wild($urandom_range(0, 6));
    end
    if ($urandom_range(0, 3) == 0) begin
      put_text("#");
      put_wild($urandom_range(0, 6));
    end
    // noise: a flipped byte, a cut or an inserted byte
    pos = $urandom_range(0, uri_buf.size() - 1);
    case ($urandom_range(0, 19))
      0, 1, 2: uri_buf[pos] = 8'($urandom_range(0, 255));
      3: while (uri_buf.size() > pos) void'(uri_buf.pop_back());
      4: uri_buf.insert(pos, 8'($urandom_range(0, 255)));
      default: ;
    endcase
    foreach (uri_buf[k]) begin
      beat.byte_in = uri_buf[k];
      beat.end_marker = 1'b0;
      send_beat(beat, 1'b0, NO_TAG);
    end
    beat.byte_in = 8'($urandom_range(0, 255));
    beat.end_marker = 1'b1;
    send_beat(beat, 1'b0, NO_TAG);
  endtask

  // result side stall: random runs, plus a long hold when asked
  initial begin
    out_stall = 1'b0;
    stall_left = 0;
    free_left = 0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        stall_left = hold_cycles;
        hold_cycles = 0;
      end
      if (stall_left == 0 && free_left == 0) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: stall_left = 0;
          5, 6, 7: stall_left = $urandom_range(1, 3);
          8: stall_left = $urandom_range(4, 12);
          default: stall_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : 2;
        endcase
        free_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(0, 6);
      end
      if (stall_left > 0) begin
        stall_now = 1'b1;
        stall_left--;
      end else begin
        stall_now = 1'b0;
        if (free_left > 0) free_left--;
      end
      out_stall <= stall_now;
    end
  end

  // compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (tags_due.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10) $display("%0t: result with nothing pending: %s", $time, show(out_data));
      end else begin
        tag_want = tags_due.pop_front();
        if (out_data !== tag_want) begin
          fail_cnt++;
          if (fail_cnt <= 10) begin
            $display("%0t: mismatch on result %0d", $time, results_seen);
            $display("  expected %s", show(tag_want));
            $display("  actual   %s", show(out_data));
          end
        end
      end
    end
  end

  // watchdog
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles, %0d results still pending", cycle_cnt, tags_due.size());
    $display("testbench: FAIL");
    $finish;
  end

  // main sequence
  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    fail_cnt = 0;
    results_seen = 0;
    beats_sent = 0;
    valid_uris = 0;
    bad_uris = 0;
    port_clamps = 0;
    v6_hosts = 0;
    quiet_left = 0;
    hold_cycles = 0;
    held = 1'b0;
    paused = 1'b0;
    clear_parser();

    dir_tab = '{
      // end beat right after reset: nothing parsed, rejected
      '{8'h00, 1'b1, 1'b1, '{8'h00, PART_DELIM, RES_NONE, 1'b1, 1'b1, 16'd0, 1'b0}},
      // leading tab is skipped
      '{8'h09, 1'b0, 1'b1, '{8'h09, PART_DELIM, RES_NONE, 1'b0, 1'b0, 16'd0, 1'b0}},
      '{"f", 1'b0, 1'b0, NO_TAG}, '{"t", 1'b0, 1'b0, NO_TAG}, '{"p", 1'b0, 1'b0, NO_TAG},
      '{":", 1'b0, 1'b0, NO_TAG}, '{"/", 1'b0, 1'b0, NO_TAG}, '{"/", 1'b0, 1'b0, NO_TAG},
      '{"[", 1'b0, 1'b0, NO_TAG}, '{":", 1'b0, 1'b0, NO_TAG}, '{":", 1'b0, 1'b0, NO_TAG},
      '{"]", 1'b0, 1'b0, NO_TAG}, '{":", 1'b0, 1'b0, NO_TAG},
      // bare colon after the bracket: port given as zero, ftp default not used
      '{8'hA5, 1'b1, 1'b1, '{8'h00, PART_DELIM, RES_NONE, 1'b0, 1'b1, 16'd0, 1'b1}},
      // top byte in the start state breaks the uri, error stays
      '{8'hFF, 1'b0, 1'b1, '{8'hFF, PART_DELIM, RES_NONE, 1'b1, 1'b0, 16'd0, 1'b0}},
      '{8'h00, 1'b0, 1'b1, '{8'h00, PART_DELIM, RES_NONE, 1'b1, 1'b0, 16'd0, 1'b0}},
      '{8'h5A, 1'b1, 1'b1, '{8'h00, PART_DELIM, RES_NONE, 1'b1, 1'b1, 16'd0, 1'b0}},
      '{"a", 1'b0, 1'b0, NO_TAG}, '{":", 1'b0, 1'b0, NO_TAG}, '{"/", 1'b0, 1'b0, NO_TAG},
      '{"/", 1'b0, 1'b0, NO_TAG}, '{"x", 1'b0, 1'b0, NO_TAG}, '{":", 1'b0, 1'b0, NO_TAG},
      '{"7", 1'b0, 1'b0, NO_TAG}, '{"@", 1'b0, 1'b0, NO_TAG},
      // digits before the at sign: port counts as given and reads zero
      '{8'h00, 1'b1, 1'b1, '{8'h00, PART_DELIM, RES_NONE, 1'b0, 1'b1, 16'd0, 1'b0}}
    };

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed rows
    for (int i = 0; i < DIR_N; i++) begin
      send_beat('{dir_tab[i].ch, dir_tab[i].fin}, dir_tab[i].fixed, dir_tab[i].want);
    end
    wait_drained();

    // random uris, with one long result hold and one full drain on the way
    while (beats_sent < DIR_N + RAND_BEATS) begin
      if (!held && beats_sent > DIR_N + 150) begin
        hold_cycles = HOLD_CYCLES;
        held = 1'b1;
      end
      if (!paused && beats_sent > DIR_N + 350) begin
        wait_drained();
        paused = 1'b1;
      end
      send_uri();
    end

    wait_drained();
    repeat (8) @(posedge clk);

    $display("covered %0d uris (%0d accepted, %0d rejected) over %0d beats, %0d results checked",
             valid_uris + bad_uris, valid_uris, bad_uris, beats_sent, results_seen);
    $display("port clamps %0d, bracketed hosts %0d, %0d cycles, %0d failures",
             port_clamps, v6_hosts, cycle_cnt, fail_cnt);
    if (fail_cnt == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
